// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for same-cycle and next-cycle implication checks, clocked on
// clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Widths, types, weight table and saturation for coning/sculling compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int unsigned IN_W   = 32;  // Q1.30 subsample fields
  localparam int unsigned OUT_W  = 40;  // Q9.30 sums and results
  localparam int unsigned CNT_W  = 3;   // subsample count register
  localparam int unsigned W_W    = 18;  // Q2.16 unsigned weights
  localparam int unsigned FRAC_W = 30;  // fraction bits of inputs and results
  localparam int unsigned WFRAC_W = 16; // fraction bits of the weights

  localparam int unsigned MAX_SUBSAMPLES_DEF = 5;

  // weight times sample, before and after rounding
  localparam int unsigned WP_W = W_W + 1 + IN_W;
  localparam int unsigned WT_W = WP_W - WFRAC_W;

  // cross-product datapath
  localparam int unsigned HALF_W = OUT_W / 2;
  localparam int unsigned PP_W   = HALF_W + OUT_W;
  localparam int unsigned FULL_W = 2 * OUT_W;
  localparam int unsigned RM_W   = 2 * (OUT_W - 1) - FRAC_W + 1;
  localparam int unsigned XT_W   = RM_W + 2;
  localparam int unsigned SUM_W  = XT_W + 3;

  // cross-term groups
  localparam int unsigned XT_CONE = 0;  // weighted gyro x last gyro
  localparam int unsigned XT_SGA  = 1;  // weighted gyro x last accel
  localparam int unsigned XT_SAG  = 2;  // weighted accel x last gyro
  localparam int unsigned XT_HALF = 3;  // gyro sum x accel sum, halved
  localparam int unsigned XT_NUM  = 4;

  typedef logic signed [IN_W-1:0]  smp_t;
  typedef logic signed [OUT_W-1:0] acc_t;
  typedef logic signed [XT_W-1:0]  xt_t;

  // Group totals frozen on the last subsample.
  typedef struct packed {
    acc_t [2:0] gsum;
    acc_t [2:0] asum;
    acc_t [2:0] gwsum;
    acc_t [2:0] awsum;
    smp_t [2:0] glast;
    smp_t [2:0] alast;
  } snap_t;

  // Finished cross terms with the plain sums that go with them.
  typedef struct packed {
    xt_t [XT_NUM-1:0][2:0] xt;
    acc_t [2:0]            gsum;
    acc_t [2:0]            asum;
  } xterm_t;

  // Q2.16 weights; row r serves a group of r+2 subsamples.
  localparam logic [W_W-1:0] WEIGHT_TAB [4][4] = '{
    '{18'd43691, 18'd0,     18'd0,      18'd0},
    '{18'd29491, 18'd88474, 18'd0,      18'd0},
    '{18'd33704, 18'd57422, 18'd133569, 18'd0},
    '{18'd32508, 18'd68267, 18'd84521,  18'd178794}
  };

  localparam logic signed [SUM_W-1:0] SAT_HI_EXT =
    {{(SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO_EXT = ~SAT_HI_EXT;

  function automatic acc_t sat_out(input logic signed [SUM_W-1:0] v);
    acc_t r;
    if (v > SAT_HI_EXT) begin
      r = SAT_HI_EXT[OUT_W-1:0];
    end else if (v < SAT_LO_EXT) begin
      r = SAT_LO_EXT[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/csc_front.sv =====
// ----------------------------------------------------------------------------
// csc_front
// Input stage, group position, weighting and running sums; freezes the group
// totals into a snapshot register on the last subsample.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_front import csc_pkg::*; #(
  parameter int unsigned MAX_SUBSAMPLES = MAX_SUBSAMPLES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire smp_t [2:0]       gyro_i,
  input  wire smp_t [2:0]       accel_i,
  input  wire logic             adv_i,
  output snap_t                 snap_o,
  output logic                  snap_valid_o
);

  localparam int unsigned IdxW = $clog2(MAX_SUBSAMPLES + 1);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_SUBSAMPLES);
  localparam logic signed [WP_W-1:0] RndHalf = WP_W'(1) <<< (WFRAC_W - 1);

  logic [CNT_W-1:0] n_eff, idx_ext, idx_inc;
  logic             last_now;
  logic [1:0]       w_row, w_col;
  logic [W_W-1:0]   w_now;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic v1_q, v2_q, v3_q, v4_q;
  logic mv1, mv2, mv3, acc_in;

  logic signed [IN_W-1:0]  g1_q [3], a1_q [3], g2_q [3], a2_q [3], g3_q [3], a3_q [3];
  logic [W_W-1:0]          w1_q;
  logic                    last1_q, last2_q, last3_q;
  logic signed [WP_W-1:0]  pg_d [3], pa_d [3], pg2_q [3], pa2_q [3];
  logic signed [WP_W-1:0]  rg, ra;
  logic signed [WT_W-1:0]  wg_d [3], wa_d [3], wg3_q [3], wa3_q [3];

  logic signed [OUT_W-1:0] gsum_q [3], asum_q [3], gwsum_q [3], awsum_q [3];
  logic signed [OUT_W-1:0] gsum_n [3], asum_n [3], gwsum_n [3], awsum_n [3];
  snap_t                   snap_q;

  // group position and weight for the subsample at the port
  always_comb begin
    n_eff = count_i;
    if (count_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_i > MaxCnt) begin
      n_eff = MaxCnt;
    end
    idx_ext  = CNT_W'(idx_q);
    idx_inc  = idx_ext + CNT_W'(1);
    last_now = (idx_inc >= n_eff);
    idx_d    = last_now ? '0 : IdxW'(idx_inc);
    w_row    = 2'(n_eff - CNT_W'(2));
    w_col    = 2'(idx_ext);
    w_now    = WEIGHT_TAB[w_row][w_col];
  end

  // stage moves; only a closing subsample waits on the back end
  assign mv3        = v3_q & (~last3_q | adv_i);
  assign mv2        = v2_q & (~v3_q | mv3);
  assign mv1        = v1_q & (~v2_q | mv2);
  assign in_ready_o = ~v1_q | mv1;
  assign acc_in     = in_valid_i & in_ready_o;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pg_d[k] = WP_W'($signed({1'b0, w1_q})) * WP_W'(g1_q[k]);
      pa_d[k] = WP_W'($signed({1'b0, w1_q})) * WP_W'(a1_q[k]);
    end
  end

  // round half away from zero to Q.30
  always_comb begin
    rg = '0;
    ra = '0;
    for (int k = 0; k < 3; k++) begin
      rg = pg2_q[k] + (pg2_q[k][WP_W-1] ? (RndHalf - WP_W'(1)) : RndHalf);
      ra = pa2_q[k] + (pa2_q[k][WP_W-1] ? (RndHalf - WP_W'(1)) : RndHalf);
      wg_d[k] = rg[WP_W-1:WFRAC_W];
      wa_d[k] = ra[WP_W-1:WFRAC_W];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gsum_n[k]  = sat_out(SUM_W'(gsum_q[k]) + SUM_W'(g3_q[k]));
      asum_n[k]  = sat_out(SUM_W'(asum_q[k]) + SUM_W'(a3_q[k]));
      gwsum_n[k] = sat_out(SUM_W'(gwsum_q[k]) + SUM_W'(wg3_q[k]));
      awsum_n[k] = sat_out(SUM_W'(awsum_q[k]) + SUM_W'(wa3_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      idx_q <= '0;
      for (int k = 0; k < 3; k++) begin
        gsum_q[k]  <= '0;
        asum_q[k]  <= '0;
        gwsum_q[k] <= '0;
        awsum_q[k] <= '0;
      end
    end else begin
      v1_q <= acc_in | (v1_q & ~mv1);
      v2_q <= mv1 | (v2_q & ~mv2);
      v3_q <= mv2 | (v3_q & ~mv3);
      if (adv_i) begin
        v4_q <= mv3 & last3_q;
      end
      if (acc_in) begin
        idx_q <= idx_d;
      end
      if (mv3) begin
        for (int k = 0; k < 3; k++) begin
          if (last3_q) begin
            gsum_q[k]  <= '0;
            asum_q[k]  <= '0;
            gwsum_q[k] <= '0;
            awsum_q[k] <= '0;
          end else begin
            gsum_q[k]  <= gsum_n[k];
            asum_q[k]  <= asum_n[k];
            gwsum_q[k] <= gwsum_n[k];
            awsum_q[k] <= awsum_n[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      w1_q    <= w_now;
      last1_q <= last_now;
      for (int k = 0; k < 3; k++) begin
        g1_q[k] <= gyro_i[k];
        a1_q[k] <= accel_i[k];
      end
    end
    if (mv1) begin
      last2_q <= last1_q;
      for (int k = 0; k < 3; k++) begin
        g2_q[k]  <= g1_q[k];
        a2_q[k]  <= a1_q[k];
        pg2_q[k] <= pg_d[k];
        pa2_q[k] <= pa_d[k];
      end
    end
    if (mv2) begin
      last3_q <= last2_q;
      for (int k = 0; k < 3; k++) begin
        g3_q[k]  <= g2_q[k];
        a3_q[k]  <= a2_q[k];
        wg3_q[k] <= wg_d[k];
        wa3_q[k] <= wa_d[k];
      end
    end
    // freeze the group: sums include the closing subsample, weighted sums do not
    if (mv3 && last3_q) begin
      for (int k = 0; k < 3; k++) begin
        snap_q.gsum[k]  <= gsum_n[k];
        snap_q.asum[k]  <= asum_n[k];
        snap_q.gwsum[k] <= gwsum_q[k];
        snap_q.awsum[k] <= awsum_q[k];
        snap_q.glast[k] <= g3_q[k];
        snap_q.alast[k] <= a3_q[k];
      end
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = v4_q;

endmodule

`default_nettype wire

// ===== sv/csc_cross.sv =====
// ----------------------------------------------------------------------------
// csc_cross
// Four rounded cross products of a frozen group: magnitudes, split partial
// products, rounding, then signed difference. All stages step on adv_i.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_cross import csc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  adv_i,
  input  wire snap_t snap_i,
  input  wire logic  snap_valid_i,
  output xterm_t     xterm_o,
  output logic       xterm_valid_o
);

  // operand order of each cross component
  localparam int unsigned Nxt1 [3] = '{1, 2, 0};
  localparam int unsigned Nxt2 [3] = '{2, 0, 1};

  logic v5_q, v6_q, v7_q, v8_q;

  // stage 5: magnitudes and signs
  logic signed [OUT_W-1:0] op_a [XT_NUM][3], op_b [XT_NUM][3];
  logic [OUT_W-1:0]        ma_d [XT_NUM][3], mb_d [XT_NUM][3];
  logic [OUT_W-1:0]        ma_q [XT_NUM][3], mb_q [XT_NUM][3];
  logic                    na_q [XT_NUM][3], nb_q [XT_NUM][3];
  acc_t [2:0]              gs5_q, as5_q, gs6_q, as6_q, gs7_q, as7_q;

  // stage 6: split partial products
  logic [PP_W-1:0]         hi_d [XT_NUM][3][2], lo_d [XT_NUM][3][2];
  logic [PP_W-1:0]         hi_q [XT_NUM][3][2], lo_q [XT_NUM][3][2];
  logic                    ng_d [XT_NUM][3][2], ng6_q [XT_NUM][3][2], ng7_q [XT_NUM][3][2];

  // stage 7: rounded magnitudes
  logic [FULL_W-1:0]       full_v;
  logic [RM_W-1:0]         rm_d [XT_NUM][3][2], rm_q [XT_NUM][3][2];

  // stage 8: signed cross terms
  logic signed [XT_W-1:0]  t0, t1;
  xterm_t                  xt_d, xt_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      op_a[XT_CONE][c] = snap_i.gwsum[c];
      op_b[XT_CONE][c] = OUT_W'($signed(snap_i.glast[c]));
      op_a[XT_SGA][c]  = snap_i.gwsum[c];
      op_b[XT_SGA][c]  = OUT_W'($signed(snap_i.alast[c]));
      op_a[XT_SAG][c]  = snap_i.awsum[c];
      op_b[XT_SAG][c]  = OUT_W'($signed(snap_i.glast[c]));
      op_a[XT_HALF][c] = snap_i.gsum[c];
      op_b[XT_HALF][c] = snap_i.asum[c];
    end
    for (int q = 0; q < XT_NUM; q++) begin
      for (int c = 0; c < 3; c++) begin
        ma_d[q][c] = op_a[q][c][OUT_W-1] ? OUT_W'(-op_a[q][c]) : OUT_W'(op_a[q][c]);
        mb_d[q][c] = op_b[q][c][OUT_W-1] ? OUT_W'(-op_b[q][c]) : OUT_W'(op_b[q][c]);
      end
    end
  end

  always_comb begin
    int ia;
    int ib;
    for (int q = 0; q < XT_NUM; q++) begin
      for (int c = 0; c < 3; c++) begin
        for (int t = 0; t < 2; t++) begin
          ia = (t == 0) ? Nxt1[c] : Nxt2[c];
          ib = (t == 0) ? Nxt2[c] : Nxt1[c];
          hi_d[q][c][t] = PP_W'(ma_q[q][ia][OUT_W-1:HALF_W]) * PP_W'(mb_q[q][ib]);
          lo_d[q][c][t] = PP_W'(ma_q[q][ia][HALF_W-1:0]) * PP_W'(mb_q[q][ib]);
          ng_d[q][c][t] = na_q[q][ia] ^ nb_q[q][ib];
        end
      end
    end
  end

  // the halved term rounds one bit further down
  always_comb begin
    full_v = '0;
    for (int q = 0; q < XT_NUM; q++) begin
      for (int c = 0; c < 3; c++) begin
        for (int t = 0; t < 2; t++) begin
          if (q == XT_HALF) begin
            full_v = {hi_q[q][c][t], {HALF_W{1'b0}}} + FULL_W'(lo_q[q][c][t])
                   + (FULL_W'(1) << FRAC_W);
            rm_d[q][c][t] = RM_W'(full_v >> (FRAC_W + 1));
          end else begin
            full_v = {hi_q[q][c][t], {HALF_W{1'b0}}} + FULL_W'(lo_q[q][c][t])
                   + (FULL_W'(1) << (FRAC_W - 1));
            rm_d[q][c][t] = RM_W'(full_v >> FRAC_W);
          end
        end
      end
    end
  end

  always_comb begin
    t0   = '0;
    t1   = '0;
    xt_d = '0;
    for (int q = 0; q < XT_NUM; q++) begin
      for (int c = 0; c < 3; c++) begin
        t0 = $signed(XT_W'(rm_q[q][c][0]));
        t1 = $signed(XT_W'(rm_q[q][c][1]));
        if (ng7_q[q][c][0]) begin
          t0 = -t0;
        end
        if (ng7_q[q][c][1]) begin
          t1 = -t1;
        end
        xt_d.xt[q][c] = t0 - t1;
      end
    end
    xt_d.gsum = gs7_q;
    xt_d.asum = as7_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= snap_valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int q = 0; q < XT_NUM; q++) begin
        for (int c = 0; c < 3; c++) begin
          ma_q[q][c] <= ma_d[q][c];
          mb_q[q][c] <= mb_d[q][c];
          na_q[q][c] <= op_a[q][c][OUT_W-1];
          nb_q[q][c] <= op_b[q][c][OUT_W-1];
          for (int t = 0; t < 2; t++) begin
            hi_q[q][c][t]  <= hi_d[q][c][t];
            lo_q[q][c][t]  <= lo_d[q][c][t];
            ng6_q[q][c][t] <= ng_d[q][c][t];
            ng7_q[q][c][t] <= ng6_q[q][c][t];
            rm_q[q][c][t]  <= rm_d[q][c][t];
          end
        end
      end
      gs5_q <= snap_i.gsum;
      as5_q <= snap_i.asum;
      gs6_q <= gs5_q;
      as6_q <= as5_q;
      gs7_q <= gs6_q;
      as7_q <= as6_q;
      xt_q  <= xt_d;
    end
  end

  assign xterm_o       = xt_q;
  assign xterm_valid_o = v8_q;

endmodule

`default_nettype wire

// ===== sv/coning_sculling_compensation_top.sv =====
// A closing subsample passes the input stages, snapshot register, cross-product
// stages and output register. A group of N subsamples gives one result; the input
// takes one subsample per cycle and keeps taking non-closing ones while a result
// waits; a closing subsample waits only while the cross-product pipe is stalled.
// Reset (rst_ni low, asynchronous): sums, group position and all valids clear;
// the subsample count returns to 1.
// ----------------------------------------------------------------------------
// coning_sculling_compensation_top
// Multi-subsample coning and sculling compensation: accumulates gyro and
// accelerometer increments over a group and emits the compensated rotation
// vector and velocity increment, Q9.30 saturating.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module coning_sculling_compensation_top import csc_pkg::*; #(
  parameter int unsigned MAX_SUBSAMPLES = MAX_SUBSAMPLES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CNT_W-1:0] cfg_subsample_count_i,
  // subsample input
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [IN_W-1:0]  gyro_x_i,
  input  wire logic [IN_W-1:0]  gyro_y_i,
  input  wire logic [IN_W-1:0]  gyro_z_i,
  input  wire logic [IN_W-1:0]  accel_x_i,
  input  wire logic [IN_W-1:0]  accel_y_i,
  input  wire logic [IN_W-1:0]  accel_z_i,
  // compensated result
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [OUT_W-1:0]      rot_x_o,
  output logic [OUT_W-1:0]      rot_y_o,
  output logic [OUT_W-1:0]      rot_z_o,
  output logic [OUT_W-1:0]      vel_x_o,
  output logic [OUT_W-1:0]      vel_y_o,
  output logic [OUT_W-1:0]      vel_z_o
);

  logic [CNT_W-1:0] count_q;
  smp_t [2:0]       gyro, accel;
  logic             adv;
  snap_t            snap;
  logic             snap_valid;
  xterm_t           xterm;
  logic             xterm_valid;
  acc_t [2:0]       rot_d, vel_d, rot_q, vel_q;
  logic             out_valid_q;

  // Count register: always ready; the user must write it only while idle (unchecked).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      count_q <= cfg_subsample_count_i;
    end
  end

  assign gyro  = {$signed(gyro_z_i), $signed(gyro_y_i), $signed(gyro_x_i)};
  assign accel = {$signed(accel_z_i), $signed(accel_y_i), $signed(accel_x_i)};

  // The back end (snapshot, cross-product pipe, output register) steps
  // together whenever the output register is empty or being drained.
  assign adv = ~out_valid_q | out_ready_i;

  csc_front #(
    .MAX_SUBSAMPLES (MAX_SUBSAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .count_i      (count_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .gyro_i       (gyro),
    .accel_i      (accel),
    .adv_i        (adv),
    .snap_o       (snap),
    .snap_valid_o (snap_valid)
  );

  csc_cross u_cross (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .snap_i        (snap),
    .snap_valid_i  (snap_valid),
    .xterm_o       (xterm),
    .xterm_valid_o (xterm_valid)
  );

  // Final sums:
  //   rotation = gyro sum + coning term
  //   velocity = accel sum + half rotation term + both sculling terms
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rot_d[c] = sat_out(SUM_W'($signed(xterm.gsum[c]))
                       + SUM_W'($signed(xterm.xt[XT_CONE][c])));
      vel_d[c] = sat_out(SUM_W'($signed(xterm.asum[c]))
                       + SUM_W'($signed(xterm.xt[XT_HALF][c]))
                       + SUM_W'($signed(xterm.xt[XT_SGA][c]))
                       + SUM_W'($signed(xterm.xt[XT_SAG][c])));
    end
  end

  // Output register: hold while the result is stalled, refill on drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= xterm_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && xterm_valid) begin
      rot_q <= rot_d;
      vel_q <= vel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];

  // A frozen group is never dropped while the back end is stalled.
  `CSC_ASSERT_NXT(a_snap_hold, snap_valid && !adv, snap_valid, "snapshot lost under stall")
  // Cross terms hold still while the output register waits.
  `CSC_ASSERT_NXT(a_xterm_hold, xterm_valid && !adv, xterm_valid && $stable(xterm),
                  "cross terms moved under stall")
  // A drained result with nothing behind it leaves the output empty.
  `CSC_ASSERT_NXT(a_no_repeat, out_valid_q && out_ready_i && !xterm_valid, !out_valid_q,
                  "result repeated")
  // A new result comes only from a finished cross-term stage.
  `CSC_ASSERT_IMP(a_out_source, $rose(out_valid_q), $past(xterm_valid),
                  "result without cross terms")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for coning/sculling compensation: drives IMU subsample
// requests and register writes, takes each expected result from a behavioral model
// or a typed-in row, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import csc_pkg::*;

  localparam int  MAX_GROUP   = 5;     // largest group the block combines
  localparam int  SETTLE      = 12;    // quiet cycles before a register write
  localparam int  DRAIN       = 20;    // quiet cycles before the verdict
  localparam int  STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam int  RAND_ITEMS  = 1500;
  localparam longint SAT_POS  = 64'sd549755813887;
  localparam longint SAT_NEG  = -64'sd549755813888;
  localparam longint MAXI     = 64'sd2147483647;
  localparam longint MINI     = -64'sd2147483648;

  // Q2.16 coning/sculling weights, row r for a group of r+2 subsamples
  localparam longint GAIN [4][4] = '{
    '{43691, 0,     0,      0},
    '{29491, 88474, 0,      0},
    '{33704, 57422, 133569, 0},
    '{32508, 68267, 84521,  178794}
  };

  typedef struct packed {
    acc_t [2:0] rot;
    acc_t [2:0] vel;
  } comp_t;

  typedef struct {
    bit         is_cfg;
    logic [2:0] cfg;
    smp_t       g [3];
    smp_t       a [3];
    bit         known;
    comp_t      res;
  } row_t;

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_count = '0;
  logic             in_valid  = 1'b0;
  smp_t [2:0]       gyro_drv  = '0;
  smp_t [2:0]       accel_drv = '0;
  logic             out_ready = 1'b0;
  logic             cfg_ready_o, in_ready_o, out_valid_o;
  acc_t [2:0]       rot_o, vel_o;

  // model state: register, group position and the four running sums
  logic [2:0] group_size_q;
  logic [2:0] group_pos_q;
  longint     gyro_acc [3];
  longint     accel_acc [3];
  longint     gyro_wacc [3];
  longint     accel_wacc [3];

  comp_t  pending_results [$];
  row_t   directed_rows [$];
  int     errors      = 0;
  int     quiet_count = 0;
  bit     calm        = 1'b0;  // no idling on either side while set

  coning_sculling_compensation_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_subsample_count_i (cfg_count),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .gyro_x_i              (gyro_drv[0]),
    .gyro_y_i              (gyro_drv[1]),
    .gyro_z_i              (gyro_drv[2]),
    .accel_x_i             (accel_drv[0]),
    .accel_y_i             (accel_drv[1]),
    .accel_z_i             (accel_drv[2]),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .rot_x_o               (rot_o[0]),
    .rot_y_o               (rot_o[1]),
    .rot_z_o               (rot_o[2]),
    .vel_x_o               (vel_o[0]),
    .vel_y_o               (vel_o[1]),
    .vel_z_o               (vel_o[2])
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Behavioral model
  // ---------------------------------------------------------------------------
  function automatic longint clamp40(input longint v);
    if (v > SAT_POS) return SAT_POS;
    if (v < SAT_NEG) return SAT_NEG;
    return v;
  endfunction

  // a*b / 2^s, rounded half away from zero, exact over the full product
  function automatic longint round_prod(input longint a, input longint b, input int s);
    logic [127:0] ua, ub, p;
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p  = (ua * ub + (128'd1 << (s - 1))) >> s;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic void cross_rnd(input longint a [3], input longint b [3],
                                    output longint o [3], input int s);
    o[0] = round_prod(a[1], b[2], s) - round_prod(a[2], b[1], s);
    o[1] = round_prod(a[2], b[0], s) - round_prod(a[0], b[2], s);
    o[2] = round_prod(a[0], b[1], s) - round_prod(a[1], b[0], s);
  endfunction

  // Q2.16 weight times Q1.30 sample, back to Q.30 with rounding
  function automatic longint scale_w(input longint w, input longint x);
    longint p, m;
    p = w * x;
    m = ((p < 0 ? -p : p) + 32768) >> 16;
    return (p < 0) ? -m : m;
  endfunction

  function automatic void clear_group();
    group_pos_q = '0;
    for (int k = 0; k < 3; k++) begin
      gyro_acc[k]   = 0;
      accel_acc[k]  = 0;
      gyro_wacc[k]  = 0;
      accel_wacc[k] = 0;
    end
  endfunction

  // Advance the model by one subsample; return 1 when it closes a group.
  function automatic bit compensate(input smp_t g [3], input smp_t a [3],
                                    output comp_t res);
    longint gi [3], ai [3], cone [3], half [3], s1 [3], s2 [3];
    longint w;
    int     n;
    res = '0;
    n = int'(group_size_q);
    if (n < 1) n = 1;
    if (n > MAX_GROUP) n = MAX_GROUP;
    for (int k = 0; k < 3; k++) begin
      gi[k] = longint'(g[k]);
      ai[k] = longint'(a[k]);
      gyro_acc[k]  = clamp40(gyro_acc[k] + gi[k]);
      accel_acc[k] = clamp40(accel_acc[k] + ai[k]);
    end
    if (int'(group_pos_q) + 1 >= n) begin
      cross_rnd(gyro_wacc, gi, cone, 30);
      cross_rnd(gyro_wacc, ai, s1, 30);
      cross_rnd(accel_wacc, gi, s2, 30);
      cross_rnd(gyro_acc, accel_acc, half, 31);
      for (int k = 0; k < 3; k++) begin
        res.rot[k] = acc_t'(clamp40(gyro_acc[k] + cone[k]));
        res.vel[k] = acc_t'(clamp40(accel_acc[k] + half[k] + s1[k] + s2[k]));
      end
      clear_group();
      return 1'b1;
    end
    w = GAIN[(n - 2) & 3][group_pos_q & 3];
    for (int k = 0; k < 3; k++) begin
      gyro_wacc[k]  = clamp40(gyro_wacc[k] + scale_w(w, gi[k]));
      accel_wacc[k] = clamp40(accel_wacc[k] + scale_w(w, ai[k]));
    end
    group_pos_q = group_pos_q + 3'd1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one subsample request; predict at the accepting edge, in this same
  // process, so the pending queue is current before any register write looks.
  task automatic push_subsample(input smp_t g [3], input smp_t a [3],
                                input bit known, input comp_t known_res);
    comp_t res;
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      gyro_drv[k]  <= g[k];
      accel_drv[k] <= a[k];
    end
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (compensate(g, a, res)) pending_results.push_back(known ? known_res : res);
  endtask

  // Write the group size once the block has gone quiet.
  task automatic write_group_size(input logic [2:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // closing results are out, but a non-closing request may still be in flight
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_count <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    group_size_q = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic smp_t rand_field();
    case ($urandom_range(0, 9))
      0:       return smp_t'(MAXI);
      1:       return smp_t'(MINI);
      2:       return smp_t'($urandom_range(0, 511)) - smp_t'(256);
      default: return smp_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic void put_cfg(input logic [2:0] value);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg    = value;
    directed_rows.push_back(r);
  endfunction

  function automatic void put_item(input longint g0, g1, g2, a0, a1, a2);
    row_t r;
    r = '{default: '0};
    r.g[0] = smp_t'(g0); r.g[1] = smp_t'(g1); r.g[2] = smp_t'(g2);
    r.a[0] = smp_t'(a0); r.a[1] = smp_t'(a1); r.a[2] = smp_t'(a2);
    directed_rows.push_back(r);
  endfunction

  // Row whose result is plain enough to type in.
  function automatic void put_known(input longint g0, g1, g2, a0, a1, a2,
                                    input longint r0, r1, r2, v0, v1, v2);
    put_item(g0, g1, g2, a0, a1, a2);
    directed_rows[$].known      = 1'b1;
    directed_rows[$].res.rot[0] = acc_t'(r0);
    directed_rows[$].res.rot[1] = acc_t'(r1);
    directed_rows[$].res.rot[2] = acc_t'(r2);
    directed_rows[$].res.vel[0] = acc_t'(v0);
    directed_rows[$].res.vel[1] = acc_t'(v1);
    directed_rows[$].res.vel[2] = acc_t'(v2);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    smp_t       g [3];
    smp_t       a [3];
    logic [2:0] size;
    int         sent;
    int         burst;

    group_size_q = 3'd1;
    clear_group();

    // group size 1 out of reset: each request closes its own group
    put_known(1, 2, 3, 0, 0, 0,          1, 2, 3, 0, 0, 0);
    put_known(0, 0, 0, MAXI, MINI, -1,   0, 0, 0, MAXI, MINI, -1);
    put_known(MAXI, MINI, 0, 0, 0, 0,    MAXI, MINI, 0, 0, 0, 0);
    put_item(MAXI, MAXI, MINI, MINI, MAXI, MAXI);
    // pairs
    put_cfg(3'd2);
    put_item(MAXI, MINI, 12345, -7, MAXI, MINI);
    put_item(MINI, MAXI, -1, MAXI, MAXI, MINI);
    // zero acts as one
    put_cfg(3'd0);
    put_known(5, 6, 7, 0, 0, 0,          5, 6, 7, 0, 0, 0);
    // seven acts as five; full-scale extremes across the group
    put_cfg(3'd7);
    put_item(MAXI, MINI, MAXI, MINI, MAXI, MINI);
    put_item(MINI, MAXI, MINI, MAXI, MINI, MAXI);
    put_item(MAXI, MAXI, MAXI, MINI, MINI, MINI);
    put_item(MINI, MINI, MINI, MAXI, MAXI, MINI);
    put_item(MAXI, MINI, -1, MINI, MAXI, 1);
    // shrink the group below the current position: next request closes it
    put_cfg(3'd5);
    put_item(1000000, -2000000, 3000000, -4000000, 5000000, -6000000);
    put_item(MAXI, 0, MINI, 0, MAXI, MINI);
    put_cfg(3'd2);
    put_item(-123456789, 987654321, 55555, 1, -1, MAXI);
    // grow the group mid-way; earlier weights keep their old row
    put_cfg(3'd3);
    put_item(MAXI, MAXI, MINI, 777, -777, 0);
    put_cfg(3'd5);
    put_item(MINI, 314159265, -271828182, MAXI, MINI, 42);
    put_item(-1, -1, -1, MINI, MINI, MAXI);
    put_item(MAXI, MINI, MAXI, MAXI, MAXI, MAXI);
    put_item(65536, -65536, 1073741824, -1073741824, MINI, MAXI);
    put_cfg(3'd1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_group_size(directed_rows[i].cfg);
      end else begin
        push_subsample(directed_rows[i].g, directed_rows[i].a,
                       directed_rows[i].known, directed_rows[i].res);
      end
    end

    // Random phases: pick a group size, then a burst that may end mid-group,
    // so the next write also lands inside a group now and then.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        size = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
      end else begin
        size = 3'($urandom_range(1, MAX_GROUP));
      end
      write_group_size(size);
      burst = $urandom_range(5, 60);
      for (int i = 0; i < burst; i++) begin
        calm = (sent >= 500) && (sent < 800);
        for (int k = 0; k < 3; k++) begin
          g[k] = rand_field();
          a[k] = rand_field();
        end
        push_subsample(g, a, 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;

    // Drop the request, let every expected result arrive, then settle.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, then field-by-field comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  task automatic report_mismatch(input string what, input acc_t got, input acc_t want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    comp_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, rot_x", rot_o[0], '0);
      end else begin
        want = pending_results.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (rot_o[k] !== want.rot[k])
            report_mismatch($sformatf("rot[%0d]", k), rot_o[k], want.rot[k]);
          if (vel_o[k] !== want.vel[k])
            report_mismatch($sformatf("vel[%0d]", k), vel_o[k], want.vel[k]);
        end
      end
    end
  end

  // Watchdog: hold a count of cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (cfg_valid && cfg_ready_o) ||
        (out_valid_o && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

endmodule

// ===== coning_sculling_compensation_top.f =====
+incdir+sv
sv/csc_pkg.sv
sv/csc_front.sv
sv/csc_cross.sv
sv/coning_sculling_compensation_top.sv
sim/tb.sv
